// ===== design/spcp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and helpers for the segment pair closest points block.
// No dependencies.
package spcp_pkg;

  localparam int unsigned PT_W   = 32;  // Q16.16 coordinate
  localparam int unsigned DIFF_W = 33;  // exact coordinate difference
  localparam int unsigned PROD_W = 66;  // product of two differences
  localparam int unsigned ACC_W  = 67;  // sum or difference of two products
  localparam int unsigned MAG_W  = 66;  // non-negative sums, divider width
  localparam int unsigned SQ_W   = 66;  // squared distance
  localparam int unsigned DIST_W = 34;  // square root width
  localparam int unsigned REM_W  = DIST_W + 3;
  localparam int unsigned CFG_W  = 63;
  localparam int unsigned NLANE  = 4;   // candidate pairs

  typedef enum logic [0:0] {
    CFG_PARALLEL   = 1'b0,
    CFG_DEGENERATE = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_ZERO = 2'd0,
    MODE_ONE  = 2'd1,
    MODE_DIV  = 2'd2
  } mode_e;

  typedef struct packed {
    logic signed [PT_W-1:0] a_start_x;
    logic signed [PT_W-1:0] a_start_y;
    logic signed [PT_W-1:0] a_end_x;
    logic signed [PT_W-1:0] a_end_y;
    logic signed [PT_W-1:0] b_start_x;
    logic signed [PT_W-1:0] b_start_y;
    logic signed [PT_W-1:0] b_end_x;
    logic signed [PT_W-1:0] b_end_y;
  } in_t;

  typedef struct packed {
    logic        [DIST_W-1:0] distance;
    logic signed [PT_W-1:0]   near_a_x;
    logic signed [PT_W-1:0]   near_a_y;
    logic signed [PT_W-1:0]   near_b_x;
    logic signed [PT_W-1:0]   near_b_y;
    logic                     crossed;
  } out_t;

  function automatic logic signed [DIFF_W-1:0] sub32(input logic signed [PT_W-1:0] a,
                                                     input logic signed [PT_W-1:0] b);
    return {a[PT_W-1], a} - {b[PT_W-1], b};
  endfunction

  function automatic logic signed [PROD_W-1:0] smul(input logic signed [DIFF_W-1:0] a,
                                                    input logic signed [DIFF_W-1:0] b);
    logic signed [PROD_W-1:0] p;
    p = a * b;
    return p;
  endfunction

endpackage

// ===== design/spcp_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, NLANE lanes, one quotient bit per stage.
// Depends on spcp_pkg. Expects num < den; returns floor(num * 2^(F+1) / den).
module spcp_div #(
  parameter int unsigned FracBits = 24,
  parameter int unsigned SideW    = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [spcp_pkg::MAG_W-1:0]  num_i [spcp_pkg::NLANE],
  input  logic [spcp_pkg::MAG_W-1:0]  den_i [spcp_pkg::NLANE],
  input  logic [SideW-1:0]            side_i,
  output logic                        valid_o,
  output logic [FracBits:0]           quo_o [spcp_pkg::NLANE],
  output logic [SideW-1:0]            side_o
);
  import spcp_pkg::*;

  localparam int unsigned Steps = FracBits + 1;

  logic [MAG_W-1:0]  rem_q [Steps][NLANE];
  logic [MAG_W-1:0]  den_q [Steps][NLANE];
  logic [FracBits:0] quo_q [Steps][NLANE];
  logic [SideW-1:0]  side_q [Steps];
  logic [Steps-1:0]  vld_q;

  logic [MAG_W-1:0]  rem_p [Steps][NLANE];
  logic [MAG_W-1:0]  den_p [Steps][NLANE];
  logic [FracBits:0] quo_p [Steps][NLANE];
  logic [MAG_W-1:0]  dbl   [Steps][NLANE];
  logic [MAG_W:0]    dif   [Steps][NLANE];

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      rem_p[0][l] = num_i[l];
      den_p[0][l] = den_i[l];
      quo_p[0][l] = '0;
    end
    for (int s = 1; s < Steps; s++) begin
      for (int l = 0; l < NLANE; l++) begin
        rem_p[s][l] = rem_q[s-1][l];
        den_p[s][l] = den_q[s-1][l];
        quo_p[s][l] = quo_q[s-1][l];
      end
    end
    for (int s = 0; s < Steps; s++) begin
      for (int l = 0; l < NLANE; l++) begin
        dbl[s][l] = {rem_p[s][l][MAG_W-2:0], 1'b0};
        dif[s][l] = {1'b0, dbl[s][l]} - {1'b0, den_p[s][l]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < Steps; s++) begin
        for (int l = 0; l < NLANE; l++) begin
          rem_q[s][l] <= dif[s][l][MAG_W] ? dbl[s][l] : dif[s][l][MAG_W-1:0];
          den_q[s][l] <= den_p[s][l];
          quo_q[s][l] <= {quo_p[s][l][FracBits-1:0], ~dif[s][l][MAG_W]};
        end
      end
      side_q[0] <= side_i;
      for (int s = 1; s < Steps; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Steps-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[Steps-1];
  assign side_o  = side_q[Steps-1];
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      quo_o[l] = quo_q[Steps-1][l];
    end
  end

endmodule

// ===== design/spcp_isqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage, truncated result.
// Depends on spcp_pkg.
module spcp_isqrt #(
  parameter int unsigned SideW = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [spcp_pkg::SQ_W-1:0]   rad_i,
  input  logic [SideW-1:0]            side_i,
  output logic                        valid_o,
  output logic [spcp_pkg::DIST_W-1:0] root_o,
  output logic [SideW-1:0]            side_o
);
  import spcp_pkg::*;

  localparam int unsigned Steps = DIST_W;
  localparam int unsigned PadW  = 2 * DIST_W;

  logic [PadW-1:0]   rad_q  [Steps];
  logic [REM_W-1:0]  rem_q  [Steps];
  logic [DIST_W-1:0] root_q [Steps];
  logic [SideW-1:0]  side_q [Steps];
  logic [Steps-1:0]  vld_q;

  logic [PadW-1:0]   rad_p  [Steps];
  logic [REM_W-1:0]  rem_p  [Steps];
  logic [DIST_W-1:0] root_p [Steps];
  logic [REM_W-1:0]  shl    [Steps];
  logic [REM_W-1:0]  trial  [Steps];
  logic [REM_W:0]    dif    [Steps];

  always_comb begin
    rad_p[0]  = {{(PadW-SQ_W){1'b0}}, rad_i};
    rem_p[0]  = '0;
    root_p[0] = '0;
    for (int s = 1; s < Steps; s++) begin
      rad_p[s]  = rad_q[s-1];
      rem_p[s]  = rem_q[s-1];
      root_p[s] = root_q[s-1];
    end
    for (int s = 0; s < Steps; s++) begin
      shl[s]   = {rem_p[s][REM_W-3:0], rad_p[s][PadW-1-2*s -: 2]};
      trial[s] = {{(REM_W-DIST_W-2){1'b0}}, root_p[s], 2'b01};
      dif[s]   = {1'b0, shl[s]} - {1'b0, trial[s]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < Steps; s++) begin
        rad_q[s]  <= rad_p[s];
        rem_q[s]  <= dif[s][REM_W] ? shl[s] : dif[s][REM_W-1:0];
        root_q[s] <= {root_p[s][DIST_W-2:0], ~dif[s][REM_W]};
      end
      side_q[0] <= side_i;
      for (int s = 1; s < Steps; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Steps-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[Steps-1];
  assign root_o  = root_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule

// ===== design/segment_pair_closest_points.sv =====
`timescale 1ns / 1ps
// Closest points and distance between two 2D segments (signed Q16.16).
// Depends on spcp_pkg, spcp_div, spcp_isqrt.
//
// Usage:
//   Input word: both segments' endpoints, taken when in_valid_i && !in_stall_o.
//   Output word: distance, nearest point on each segment and a crossed flag,
//   taken when out_valid_o && !out_stall_i. One output word per input word,
//   in order.
//   Config: cfg_we_i writes cfg_wdata_i into the register picked by cfg_idx_i
//   (parallel limit, degenerate limit). Write only while no word is in flight.
// Timing:
//   Fully pipelined, one word per cycle unless the output is stalled. The
//   pipeline has 5 setup stages, one divider stage per parameter bit
//   (PARAM_FRAC_BITS + 1), 8 stages for interpolation and candidate choice,
//   34 square-root stages and the output register.
// Reset: clears all valid bits and both limits to zero; pipeline empties.
// Backpressure: while the output word is held by out_stall_i the whole
//   pipeline freezes and in_stall_o is raised; nothing is dropped or repeated.
module segment_pair_closest_points #(
  parameter int unsigned PARAM_FRAC_BITS = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  spcp_pkg::in_t              in_word_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output spcp_pkg::out_t             out_word_o,
  input  logic                       cfg_we_i,
  input  spcp_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [spcp_pkg::CFG_W-1:0] cfg_wdata_i
);
  import spcp_pkg::*;

  localparam int unsigned QW   = PARAM_FRAC_BITS + 1;   // parameter width
  localparam int unsigned LP_W = DIFF_W + QW + 1;       // interpolation product
  localparam int unsigned NPROD = 18;
  localparam int unsigned NACC  = 9;
  // sum slots
  localparam int unsigned ACC_DEN  = 0;
  localparam int unsigned ACC_TN   = 1;
  localparam int unsigned ACC_UN   = 2;
  localparam int unsigned ACC_LENB = 3;
  localparam int unsigned ACC_LENA = 4;
  localparam int unsigned ACC_N0   = 5;

  typedef struct packed {
    in_t                      pt;
    logic signed [DIFF_W-1:0] rx;
    logic signed [DIFF_W-1:0] ry;
    logic signed [DIFF_W-1:0] sx;
    logic signed [DIFF_W-1:0] sy;
  } geo_t;

  typedef struct packed {
    geo_t                   geo;
    logic                   crossed;
    mode_e [NLANE-1:0]      mode;
  } side_t;

  typedef struct packed {
    in_t  pt;
    logic crossed;
  } pside_t;

  typedef struct packed {
    logic signed [PT_W-1:0] ax;
    logic signed [PT_W-1:0] ay;
    logic signed [PT_W-1:0] bx;
    logic signed [PT_W-1:0] by;
  } cand_t;

  typedef struct packed {
    logic                   crossed;
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
  } xinfo_t;

  typedef struct packed {
    cand_t pts;
    logic  crossed;
  } res_t;

  // ---------------------------------------------------------------- control
  logic       adv;
  logic       out_valid_q;
  out_t       out_q;
  logic [4:0] fv_q;   // setup stages 1..5
  logic [7:0] bv_q;   // stages 6..13
  logic       div_valid, sq_valid;

  // whole pipeline moves unless a finished word is held at the output
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  logic [CFG_W-1:0] par_lim_q, deg_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_lim_q <= '0;
      deg_lim_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PARALLEL:   par_lim_q <= cfg_wdata_i;
        CFG_DEGENERATE: deg_lim_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q        <= '0;
      bv_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      fv_q        <= {fv_q[3:0], in_valid_i};
      bv_q        <= {bv_q[6:0], div_valid};
      out_valid_q <= sq_valid;
    end
  end

  // ------------------------------------------------------- S1: differences
  geo_t                     s1_geo_q;
  logic signed [DIFF_W-1:0] s1_wx_q, s1_wy_q, s1_e0x_q, s1_e0y_q;
  logic signed [DIFF_W-1:0] s1_e1x_q, s1_e1y_q, s1_e3x_q, s1_e3y_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_geo_q.pt <= in_word_i;
      s1_geo_q.rx <= sub32(in_word_i.a_end_x, in_word_i.a_start_x);
      s1_geo_q.ry <= sub32(in_word_i.a_end_y, in_word_i.a_start_y);
      s1_geo_q.sx <= sub32(in_word_i.b_end_x, in_word_i.b_start_x);
      s1_geo_q.sy <= sub32(in_word_i.b_end_y, in_word_i.b_start_y);
      s1_wx_q     <= sub32(in_word_i.b_start_x, in_word_i.a_start_x);
      s1_wy_q     <= sub32(in_word_i.b_start_y, in_word_i.a_start_y);
      s1_e0x_q    <= sub32(in_word_i.a_start_x, in_word_i.b_start_x);
      s1_e0y_q    <= sub32(in_word_i.a_start_y, in_word_i.b_start_y);
      s1_e1x_q    <= sub32(in_word_i.a_end_x, in_word_i.b_start_x);
      s1_e1y_q    <= sub32(in_word_i.a_end_y, in_word_i.b_start_y);
      s1_e3x_q    <= sub32(in_word_i.b_end_x, in_word_i.a_start_x);
      s1_e3y_q    <= sub32(in_word_i.b_end_y, in_word_i.a_start_y);
    end
  end

  // ---------------------------------------------------------- S2: products
  // pairs feed S3: cross, t numerator, u numerator, |s|^2, |r|^2,
  // then the four projection numerators
  logic signed [DIFF_W-1:0] opa [NPROD];
  logic signed [DIFF_W-1:0] opb [NPROD];
  logic signed [PROD_W-1:0] s2_prod_q [NPROD];
  geo_t                     s2_geo_q;

  always_comb begin
    opa[0]  = s1_geo_q.rx; opb[0]  = s1_geo_q.sy;
    opa[1]  = s1_geo_q.ry; opb[1]  = s1_geo_q.sx;
    opa[2]  = s1_wx_q;     opb[2]  = s1_geo_q.sy;
    opa[3]  = s1_wy_q;     opb[3]  = s1_geo_q.sx;
    opa[4]  = s1_wx_q;     opb[4]  = s1_geo_q.ry;
    opa[5]  = s1_wy_q;     opb[5]  = s1_geo_q.rx;
    opa[6]  = s1_geo_q.sx; opb[6]  = s1_geo_q.sx;
    opa[7]  = s1_geo_q.sy; opb[7]  = s1_geo_q.sy;
    opa[8]  = s1_geo_q.rx; opb[8]  = s1_geo_q.rx;
    opa[9]  = s1_geo_q.ry; opb[9]  = s1_geo_q.ry;
    opa[10] = s1_e0x_q;    opb[10] = s1_geo_q.sx;
    opa[11] = s1_e0y_q;    opb[11] = s1_geo_q.sy;
    opa[12] = s1_e1x_q;    opb[12] = s1_geo_q.sx;
    opa[13] = s1_e1y_q;    opb[13] = s1_geo_q.sy;
    opa[14] = s1_wx_q;     opb[14] = s1_geo_q.rx;
    opa[15] = s1_wy_q;     opb[15] = s1_geo_q.ry;
    opa[16] = s1_e3x_q;    opb[16] = s1_geo_q.rx;
    opa[17] = s1_e3y_q;    opb[17] = s1_geo_q.ry;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NPROD; i++) begin
        s2_prod_q[i] <= smul(opa[i], opb[i]);
      end
      s2_geo_q <= s1_geo_q;
    end
  end

  // -------------------------------------------------------------- S3: sums
  logic signed [ACC_W-1:0] s3_acc_q [NACC];
  geo_t                    s3_geo_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NACC; i++) begin
        if (i <= ACC_UN) begin
          s3_acc_q[i] <= {s2_prod_q[2*i][PROD_W-1], s2_prod_q[2*i]}
                       - {s2_prod_q[2*i+1][PROD_W-1], s2_prod_q[2*i+1]};
        end else begin
          s3_acc_q[i] <= {s2_prod_q[2*i][PROD_W-1], s2_prod_q[2*i]}
                       + {s2_prod_q[2*i+1][PROD_W-1], s2_prod_q[2*i+1]};
        end
      end
      s3_geo_q <= s2_geo_q;
    end
  end

  // --------------------------------- S4: sign fix and per-lane range checks
  logic signed [ACC_W-1:0] s4_denp_q, s4_tnp_q, s4_unp_q;
  logic signed [ACC_W-1:0] s4_num_q [NLANE];
  logic signed [ACC_W-1:0] s4_len_q [NLANE];
  logic [NLANE-1:0]        s4_nz_q, s4_full_q, s4_deg_q;
  geo_t                    s4_geo_q;
  logic                    den_neg;
  logic signed [ACC_W-1:0] lane_len [NLANE];
  logic signed [ACC_W-1:0] deg_lim_x, par_lim_x;

  assign den_neg   = s3_acc_q[ACC_DEN][ACC_W-1];
  assign deg_lim_x = {{(ACC_W-CFG_W){1'b0}}, deg_lim_q};
  assign par_lim_x = {{(ACC_W-CFG_W){1'b0}}, par_lim_q};

  always_comb begin
    for (int k = 0; k < NLANE; k++) begin
      lane_len[k] = (k < 2) ? s3_acc_q[ACC_LENB] : s3_acc_q[ACC_LENA];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_denp_q <= den_neg ? -s3_acc_q[ACC_DEN] : s3_acc_q[ACC_DEN];
      s4_tnp_q  <= den_neg ? -s3_acc_q[ACC_TN]  : s3_acc_q[ACC_TN];
      s4_unp_q  <= den_neg ? -s3_acc_q[ACC_UN]  : s3_acc_q[ACC_UN];
      for (int k = 0; k < NLANE; k++) begin
        s4_num_q[k]  <= s3_acc_q[ACC_N0+k];
        s4_len_q[k]  <= lane_len[k];
        s4_nz_q[k]   <= s3_acc_q[ACC_N0+k][ACC_W-1] || (s3_acc_q[ACC_N0+k] == '0);
        s4_full_q[k] <= s3_acc_q[ACC_N0+k] >= lane_len[k];
        // squared length is never negative
        s4_deg_q[k]  <= lane_len[k] <= deg_lim_x;
      end
      s4_geo_q <= s3_geo_q;
    end
  end

  // ------------------------------- S5: crossing test and lane mode choice
  logic             crossed;
  side_t            s5_side_d, s5_side_q;
  logic [MAG_W-1:0] s5_num_d [NLANE];
  logic [MAG_W-1:0] s5_den_d [NLANE];
  logic [MAG_W-1:0] s5_num_q [NLANE];
  logic [MAG_W-1:0] s5_den_q [NLANE];

  // endpoint touches (parameter exactly 0 or 1) count as crossing
  assign crossed = (s4_denp_q > par_lim_x)
                && !s4_tnp_q[ACC_W-1] && (s4_tnp_q <= s4_denp_q)
                && !s4_unp_q[ACC_W-1] && (s4_unp_q <= s4_denp_q);

  always_comb begin
    s5_side_d.geo     = s4_geo_q;
    s5_side_d.crossed = crossed;
    for (int k = 0; k < NLANE; k++) begin
      s5_num_d[k] = s4_num_q[k][MAG_W-1:0];
      s5_den_d[k] = s4_len_q[k][MAG_W-1:0];
      if (s4_deg_q[k] || s4_nz_q[k]) begin
        s5_side_d.mode[k] = MODE_ZERO;   // degenerate gives its start point
      end else if (s4_full_q[k]) begin
        s5_side_d.mode[k] = MODE_ONE;
      end else begin
        s5_side_d.mode[k] = MODE_DIV;
      end
    end
    // crossing reuses lane 0 for the parameter along A
    if (crossed) begin
      s5_num_d[0] = s4_tnp_q[MAG_W-1:0];
      s5_den_d[0] = s4_denp_q[MAG_W-1:0];
      if (s4_tnp_q == '0) begin
        s5_side_d.mode[0] = MODE_ZERO;
      end else if (s4_tnp_q == s4_denp_q) begin
        s5_side_d.mode[0] = MODE_ONE;
      end else begin
        s5_side_d.mode[0] = MODE_DIV;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_side_q <= s5_side_d;
      for (int k = 0; k < NLANE; k++) begin
        s5_num_q[k] <= s5_num_d[k];
        s5_den_q[k] <= s5_den_d[k];
      end
    end
  end

  // ------------------------------------------------------------- divider
  logic [QW-1:0] quo [NLANE];
  side_t         div_side;

  spcp_div #(
    .FracBits (PARAM_FRAC_BITS),
    .SideW    ($bits(side_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (fv_q[4]),
    .num_i   (s5_num_q),
    .den_i   (s5_den_q),
    .side_i  (s5_side_q),
    .valid_o (div_valid),
    .quo_o   (quo),
    .side_o  (div_side)
  );

  // ------------------------------------ S6: round parameter, apply clamp
  logic [QW-1:0] s6_tq_q [NLANE];
  logic [QW:0]   quo_inc [NLANE];
  side_t         s6_side_q;

  always_comb begin
    for (int k = 0; k < NLANE; k++) begin
      quo_inc[k] = {1'b0, quo[k]} + {{QW{1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NLANE; k++) begin
        case (div_side.mode[k])
          MODE_ZERO: s6_tq_q[k] <= '0;
          MODE_ONE:  s6_tq_q[k] <= QW'(1) << PARAM_FRAC_BITS;
          default:   s6_tq_q[k] <= quo_inc[k][QW:1];
        endcase
      end
      s6_side_q <= div_side;
    end
  end

  // ------------------------------------ S7: direction times parameter
  // lane order x then y: element 2*k+c
  logic signed [DIFF_W-1:0] dir   [2*NLANE];
  logic signed [PT_W-1:0]   start [2*NLANE];
  logic signed [LP_W-1:0]   s7_lp_q    [2*NLANE];
  logic signed [PT_W-1:0]   s7_start_q [2*NLANE];
  pside_t                   s7_side_q;

  always_comb begin
    for (int k = 0; k < NLANE; k++) begin
      if (k >= 2 || (k == 0 && s6_side_q.crossed)) begin
        dir[2*k]     = s6_side_q.geo.rx;
        dir[2*k+1]   = s6_side_q.geo.ry;
        start[2*k]   = s6_side_q.geo.pt.a_start_x;
        start[2*k+1] = s6_side_q.geo.pt.a_start_y;
      end else begin
        dir[2*k]     = s6_side_q.geo.sx;
        dir[2*k+1]   = s6_side_q.geo.sy;
        start[2*k]   = s6_side_q.geo.pt.b_start_x;
        start[2*k+1] = s6_side_q.geo.pt.b_start_y;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 2*NLANE; i++) begin
        s7_lp_q[i]    <= dir[i] * $signed({1'b0, s6_tq_q[i/2]});
        s7_start_q[i] <= start[i];
      end
      s7_side_q.pt      <= s6_side_q.geo.pt;
      s7_side_q.crossed <= s6_side_q.crossed;
    end
  end

  // ------------------------------------ S8: round and offset from start
  logic signed [LP_W-1:0] lp_rnd [2*NLANE];
  logic signed [LP_W-1:0] lp_sh  [2*NLANE];
  logic signed [PT_W-1:0] s8_pt_q [2*NLANE];
  pside_t                 s8_side_q;

  always_comb begin
    for (int i = 0; i < 2*NLANE; i++) begin
      lp_rnd[i] = s7_lp_q[i] + (LP_W'(1) << (PARAM_FRAC_BITS - 1));
      lp_sh[i]  = lp_rnd[i] >>> PARAM_FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 2*NLANE; i++) begin
        s8_pt_q[i] <= s7_start_q[i] + lp_sh[i][PT_W-1:0];
      end
      s8_side_q <= s7_side_q;
    end
  end

  // ------------------------------------ S9: candidate pairs and deltas
  cand_t                    cand [NLANE];
  cand_t                    s9_cand_q [NLANE];
  logic signed [DIFF_W-1:0] s9_dd_q [2*NLANE];
  xinfo_t                   s9_x_q;

  always_comb begin
    cand[0] = '{ax: s8_side_q.pt.a_start_x, ay: s8_side_q.pt.a_start_y,
                bx: s8_pt_q[0], by: s8_pt_q[1]};
    cand[1] = '{ax: s8_side_q.pt.a_end_x, ay: s8_side_q.pt.a_end_y,
                bx: s8_pt_q[2], by: s8_pt_q[3]};
    cand[2] = '{ax: s8_pt_q[4], ay: s8_pt_q[5],
                bx: s8_side_q.pt.b_start_x, by: s8_side_q.pt.b_start_y};
    cand[3] = '{ax: s8_pt_q[6], ay: s8_pt_q[7],
                bx: s8_side_q.pt.b_end_x, by: s8_side_q.pt.b_end_y};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NLANE; k++) begin
        s9_cand_q[k]   <= cand[k];
        s9_dd_q[2*k]   <= sub32(cand[k].ax, cand[k].bx);
        s9_dd_q[2*k+1] <= sub32(cand[k].ay, cand[k].by);
      end
      // lane 0 holds the crossing point when crossed
      s9_x_q.crossed <= s8_side_q.crossed;
      s9_x_q.x       <= s8_pt_q[0];
      s9_x_q.y       <= s8_pt_q[1];
    end
  end

  // ------------------------------------ S10: squares, S11: squared distance
  logic signed [PROD_W-1:0] s10_sq_q [2*NLANE];
  cand_t                    s10_cand_q [NLANE];
  xinfo_t                   s10_x_q;
  logic [SQ_W:0]            d_sum [NLANE];
  logic [SQ_W-1:0]          s11_d_q [NLANE];
  cand_t                    s11_cand_q [NLANE];
  xinfo_t                   s11_x_q;

  always_comb begin
    for (int k = 0; k < NLANE; k++) begin
      d_sum[k] = {1'b0, s10_sq_q[2*k]} + {1'b0, s10_sq_q[2*k+1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 2*NLANE; i++) begin
        s10_sq_q[i] <= smul(s9_dd_q[i], s9_dd_q[i]);
      end
      s10_cand_q <= s9_cand_q;
      s10_x_q    <= s9_x_q;
      for (int k = 0; k < NLANE; k++) begin
        s11_d_q[k] <= d_sum[k][SQ_W-1:0];
      end
      s11_cand_q <= s10_cand_q;
      s11_x_q    <= s10_x_q;
    end
  end

  // ----- S12/S13: strict minimum, earlier pair on ties, or the crossing point
  logic [SQ_W-1:0] s12_d_q [2];
  cand_t           s12_cand_q [2];
  xinfo_t          s12_x_q;
  logic [SQ_W-1:0] s13_d_q;
  res_t            s13_res_q;
  logic            pick_hi;

  assign pick_hi = s12_d_q[1] < s12_d_q[0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int h = 0; h < 2; h++) begin
        if (s11_d_q[2*h+1] < s11_d_q[2*h]) begin
          s12_d_q[h]    <= s11_d_q[2*h+1];
          s12_cand_q[h] <= s11_cand_q[2*h+1];
        end else begin
          s12_d_q[h]    <= s11_d_q[2*h];
          s12_cand_q[h] <= s11_cand_q[2*h];
        end
      end
      s12_x_q <= s11_x_q;

      s13_res_q.crossed <= s12_x_q.crossed;
      if (s12_x_q.crossed) begin
        s13_d_q          <= '0;
        s13_res_q.pts.ax <= s12_x_q.x;
        s13_res_q.pts.ay <= s12_x_q.y;
        s13_res_q.pts.bx <= s12_x_q.x;
        s13_res_q.pts.by <= s12_x_q.y;
      end else begin
        s13_d_q       <= pick_hi ? s12_d_q[1] : s12_d_q[0];
        s13_res_q.pts <= pick_hi ? s12_cand_q[1] : s12_cand_q[0];
      end
    end
  end

  // ------------------------------------------------------- square root
  logic [DIST_W-1:0] root;
  res_t              sq_res;

  spcp_isqrt #(
    .SideW ($bits(res_t))
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (bv_q[7]),
    .rad_i   (s13_d_q),
    .side_i  (s13_res_q),
    .valid_o (sq_valid),
    .root_o  (root),
    .side_o  (sq_res)
  );

  // ------------------------------------------------------- output word
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.distance <= root;
      out_q.near_a_x <= sq_res.pts.ax;
      out_q.near_a_y <= sq_res.pts.ay;
      out_q.near_b_x <= sq_res.pts.bx;
      out_q.near_b_y <= sq_res.pts.by;
      out_q.crossed  <= sq_res.crossed;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // ------------------------------------------------------- assertions
  a_cross_zero_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.crossed |-> out_word_o.distance == '0)
    else $error("crossed word with nonzero distance");

  a_cross_same_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.crossed |->
      out_word_o.near_a_x == out_word_o.near_b_x &&
      out_word_o.near_a_y == out_word_o.near_b_y)
    else $error("crossed word with different nearest points");

  a_stall_only_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with no held output word");

endmodule
